[hw/rtl/dcwy_pkg.sv]
// Package for the date check with weekday and day-of-year block.
// Holds the channel payload types, the inter-stage types and the month offset table.
// No dependencies.
package dcwy_pkg;

   localparam logic [11:0] YEAR_BASE     = 12'd1900;
   localparam logic [7:0]  YEAR_LOW      = 8'd100;
   localparam logic [7:0]  YEAR_HIGH     = 8'd199;
   localparam logic [3:0]  MONTH_LAST    = 4'd11;
   localparam logic [3:0]  MONTH_MARCH   = 4'd2;
   localparam logic [3:0]  MONTH_JULY    = 4'd6;
   localparam logic [4:0]  HOUR_LAST     = 5'd23;
   localparam logic [5:0]  MINSEC_LAST   = 6'd59;
   localparam logic [2:0]  WEEKDAY_LAST  = 3'd6;
   localparam logic [11:0] YEAR_1900     = 12'd1900;
   localparam logic [11:0] YEAR_2000     = 12'd2000;
   localparam logic [11:0] YEAR_2100     = 12'd2100;
   localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

   typedef struct packed {
      logic [7:0] year_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] stated_weekday;
   } req_type;

   typedef struct packed {
      logic       date_valid;
      logic [2:0] weekday;
      logic [8:0] day_of_year;
   } rsp_type;

   // After the first stage: adjusted full year and range checks
   typedef struct packed {
      logic        date_valid;
      logic        month_ok;
      logic [11:0] year_adj;
      logic [3:0]  month_index;
      logic [4:0]  day_of_month;
   } s1_type;

   // After the second stage: unreduced weekday sum and day of year
   typedef struct packed {
      logic        date_valid;
      logic        month_ok;
      logic [11:0] week_sum;
      logic [8:0]  day_of_year;
   } s2_type;

   // Month offset table of the weekday method
   function automatic logic [2:0] month_offset(input logic [3:0] mon);
      logic [2:0] off;
      unique case (mon)
         4'd0:    off = 3'd0;
         4'd1:    off = 3'd3;
         4'd2:    off = 3'd2;
         4'd3:    off = 3'd5;
         4'd4:    off = 3'd0;
         4'd5:    off = 3'd3;
         4'd6:    off = 3'd5;
         4'd7:    off = 3'd1;
         4'd8:    off = 3'd4;
         4'd9:    off = 3'd6;
         4'd10:   off = 3'd2;
         4'd11:   off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction

endpackage

[hw/rtl/dcwy_prep.sv]
// First pipeline stage: range checks and the full year, adjusted for January and February.
// Depends on dcwy_pkg.
module dcwy_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  dcwy_pkg::req_type in_data,
   output logic             out_valid,
   output dcwy_pkg::s1_type out_data
);
   import dcwy_pkg::*;

   logic    valid_ff;
   s1_type  data_ff;
   s1_type  data_in;
   logic    jan_feb;

   // Check every field and form the year used by the weekday sum
   always_comb begin
      jan_feb = (in_data.month_index < MONTH_MARCH);
      data_in.date_valid = (in_data.hour <= HOUR_LAST) &&
                           (in_data.minute <= MINSEC_LAST) &&
                           (in_data.second <= MINSEC_LAST) &&
                           (in_data.year_since_1900 >= YEAR_LOW) &&
                           (in_data.year_since_1900 <= YEAR_HIGH) &&
                           (in_data.month_index <= MONTH_LAST) &&
                           (in_data.stated_weekday <= WEEKDAY_LAST) &&
                           (in_data.day_of_month != 5'd0);
      data_in.month_ok     = (in_data.month_index <= MONTH_LAST);
      data_in.year_adj     = {4'd0, in_data.year_since_1900} + YEAR_BASE - {11'd0, jan_feb};
      data_in.month_index  = in_data.month_index;
      data_in.day_of_month = in_data.day_of_month;
   end

   // Load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/dcwy_calc.sv]
// Second pipeline stage: weekday sum before reduction and the day-of-year count.
// Depends on dcwy_pkg.
module dcwy_calc (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  dcwy_pkg::s1_type in_data,
   output logic             out_valid,
   output dcwy_pkg::s2_type out_data
);
   import dcwy_pkg::*;

   logic        valid_ff;
   s2_type      data_ff;
   s2_type      data_in;
   logic [11:0] y;
   logic [3:0]  mon;
   logic [4:0]  q100;
   logic [2:0]  q400;
   logic        leap;
   logic [8:0]  mon30;
   logic [8:0]  tail;

   always_comb begin
      y   = in_data.year_adj;
      mon = in_data.month_index;

      // Century terms over the year span 1899 to 2155
      priority if (y < YEAR_1900) begin
         q100 = 5'd18;
      end else if (y < YEAR_2000) begin
         q100 = 5'd19;
      end else if (y < YEAR_2100) begin
         q100 = 5'd20;
      end else begin
         q100 = 5'd21;
      end
      q400 = (y < YEAR_2000) ? 3'd4 : 3'd5;

      // Leap only matters from March on, where the year is not adjusted
      leap = (y[1:0] == 2'b00) && (y != YEAR_1900) && (y != YEAR_2100);

      data_in.week_sum = {7'd0, in_data.day_of_month} + {9'd0, month_offset(mon)} + y +
                         {2'd0, y[11:2]} - {7'd0, q100} + {9'd0, q400};

      // Thirty days a month, plus one for each long month passed
      mon30 = ({5'd0, mon} << 5) - ({5'd0, mon} << 1);
      if (mon > MONTH_JULY) begin
         tail = 9'd4 + ({5'd0, mon - MONTH_JULY} >> 1);
      end else begin
         tail = {5'd0, mon + 4'd1} >> 1;
      end
      data_in.day_of_year = {4'd0, in_data.day_of_month} + mon30 + tail +
                            {8'd0, leap && (mon >= MONTH_MARCH)};

      data_in.date_valid = in_data.date_valid;
      data_in.month_ok   = in_data.month_ok;
   end

   // Load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/dcwy_mod7.sv]
// Third pipeline stage: reduce the weekday sum modulo seven and form the result item.
// Depends on dcwy_pkg.
module dcwy_mod7 (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  dcwy_pkg::s2_type  in_data,
   output logic              out_valid,
   output dcwy_pkg::rsp_type out_data
);
   import dcwy_pkg::*;

   logic       valid_ff;
   rsp_type    data_ff;
   rsp_type    data_in;
   logic [4:0] fold1;
   logic [3:0] fold2;
   logic [2:0] rem;

   always_comb begin
      // Eight is one modulo seven: add the octal digits, twice
      fold1 = {2'd0, in_data.week_sum[2:0]} + {2'd0, in_data.week_sum[5:3]} +
              {2'd0, in_data.week_sum[8:6]} + {2'd0, in_data.week_sum[11:9]};
      fold2 = {1'd0, fold1[2:0]} + {2'd0, fold1[4:3]};
      if (fold2 >= {1'd0, DAYS_PER_WEEK}) begin
         rem = 3'(fold2 - {1'd0, DAYS_PER_WEEK});
      end else begin
         rem = fold2[2:0];
      end

      // Drop computed values for a month beyond December
      data_in.date_valid  = in_data.date_valid;
      data_in.weekday     = in_data.month_ok ? rem : 3'd0;
      data_in.day_of_year = in_data.month_ok ? in_data.day_of_year : 9'd0;
   end

   // Load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/date_check_weekday_yearday.sv]
// Top level of the date check with computed weekday and day of year.
// Instantiates dcwy_prep, dcwy_calc and dcwy_mod7; types from dcwy_pkg.
//
//   channel   ports                            direction   payload
//   request   req_valid req_stall req_payload  in          req_type (date and time)
//   response  rsp_valid rsp_stall rsp_payload  out         rsp_type (flag, weekday, yday)
//
// Three register stages; an item's result is on the response ports from the last of them,
// the dcwy_mod7 register, and is held there while the response side stalls.
// One item is accepted every cycle while the response side does not stall.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// Synchronous reset empties all stages; no clearing pass is needed.
module date_check_weekday_yearday (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dcwy_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcwy_pkg::rsp_type rsp_payload
);
   import dcwy_pkg::*;

   logic    s1_valid;
   logic    s2_valid;
   s1_type  s1_data;
   s2_type  s2_data;
   logic    adv1;
   logic    adv2;
   logic    adv3;

   // Advance each stage when it is empty or its successor moves
   assign adv3      = !rsp_valid || !rsp_stall;
   assign adv2      = !s2_valid || adv3;
   assign adv1      = !s1_valid || adv2;
   assign req_stall = !adv1;

   dcwy_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv1),
      .in_valid  (req_valid),
      .in_data   (req_payload),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   dcwy_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv2),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   dcwy_mod7 u_mod7 (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv3),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload)
   );

endmodule

[tb/tb_date_check_weekday_yearday.sv]
// Self-checking testbench for date_check_weekday_yearday: directed dates, then random ones.
// Predicts validity flag, weekday and day of year per item; idles both channels at random.
// Depends on dcwy_pkg and the date_check_weekday_yearday RTL.
module tb_date_check_weekday_yearday;
   import dcwy_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RESET_CYCLES = 11;

   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type result;
   } date_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Typed-in expectation travelling alongside the item being offered
   bit      pinned;
   rsp_type pinned_result;

   rsp_type pending_dates[$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      burst = 1'b0;

   date_check_weekday_yearday dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Month offsets of the weekday method, January first
   function automatic int unsigned month_shift(input logic [3:0] mon);
      case (mon)
         4'd1, 4'd5:  return 3;
         4'd2, 4'd10: return 2;
         4'd3, 4'd6:  return 5;
         4'd7:        return 1;
         4'd8, 4'd11: return 4;
         4'd9:        return 6;
         default:     return 0;
      endcase
   endfunction

   function automatic bit is_leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // Validity flag, weekday and thirty-day-approximated day of year of one date
   function automatic rsp_type date_result(input req_type d);
      rsp_type     r;
      int unsigned full_year;
      int unsigned y;
      int unsigned wsum;
      int unsigned doy;
      int unsigned m;
      r.date_valid = (d.hour <= HOUR_LAST) && (d.minute <= MINSEC_LAST) &&
                     (d.second <= MINSEC_LAST) && (d.year_since_1900 >= YEAR_LOW) &&
                     (d.year_since_1900 <= YEAR_HIGH) && (d.month_index <= MONTH_LAST) &&
                     (d.stated_weekday <= WEEKDAY_LAST) && (d.day_of_month != 0);
      r.weekday     = '0;
      r.day_of_year = '0;
      if (d.month_index <= MONTH_LAST) begin
         full_year = d.year_since_1900 + 1900;
         // January and February count with the previous year
         y    = (d.month_index < 2) ? full_year - 1 : full_year;
         wsum = d.day_of_month + month_shift(d.month_index) + y + y / 4 - y / 100 + y / 400;
         r.weekday = 3'(wsum % 7);
         m   = d.month_index;
         doy = d.day_of_month + 30 * m;
         if (m > 1 && is_leap_year(full_year))
            doy = doy + 1;
         if (m > 6) begin
            doy = doy + 4;
            m   = m - 7;
         end
         r.day_of_year = 9'(doy + (m + 1) / 2);
      end
      return r;
   endfunction

   function automatic req_type mk(input int yr, input int mon, input int day, input int hr,
                                  input int mn, input int sc, input int wd);
      req_type d;
      d.year_since_1900 = 8'(yr);
      d.month_index     = 4'(mon);
      d.day_of_month    = 5'(day);
      d.hour            = 5'(hr);
      d.minute          = 6'(mn);
      d.second          = 6'(sc);
      d.stated_weekday  = 3'(wd);
      return d;
   endfunction

   function automatic rsp_type res(input bit ok, input int wk, input int yd);
      rsp_type r;
      r.date_valid  = ok;
      r.weekday     = 3'(wk);
      r.day_of_year = 9'(yd);
      return r;
   endfunction

   // Mostly legal dates; some fields, or the whole item, spread over their full width
   function automatic req_type random_date();
      req_type  d;
      bit       loose;
      bit [6:0] wild;
      int       i;
      loose = ($urandom_range(0, 4) == 0);
      for (i = 0; i < 7; i++)
         wild[i] = loose || ($urandom_range(0, 15) == 0);
      d.year_since_1900 = 8'(wild[0] ? $urandom_range(0, 255) : $urandom_range(100, 199));
      d.month_index     = 4'(wild[1] ? $urandom_range(0, 15)  : $urandom_range(0, 11));
      d.day_of_month    = 5'(wild[2] ? $urandom_range(0, 31)  : $urandom_range(1, 31));
      d.hour            = 5'(wild[3] ? $urandom_range(0, 31)  : $urandom_range(0, 23));
      d.minute          = 6'(wild[4] ? $urandom_range(0, 63)  : $urandom_range(0, 59));
      d.second          = 6'(wild[5] ? $urandom_range(0, 63)  : $urandom_range(0, 59));
      d.stated_weekday  = 3'(wild[6] ? $urandom_range(0, 7)   : $urandom_range(0, 6));
      return d;
   endfunction

   // Offer one item after a random gap and hold it until it is taken
   task automatic send_date(input req_type item, input bit is_pinned, input rsp_type result);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_payload   <= item;
      pinned        <= is_pinned;
      pinned_result <= result;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Request side: reset, directed table, random dates, drain
   initial begin
      date_row_type rows[$];
      int           n;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_payload   <= '0;
      pinned        <= 1'b0;
      pinned_result <= '0;

      // First and last day of the legal range, all-zero and all-one items
      rows.push_back('{mk(100, 0, 1, 0, 0, 0, 6), 1'b1, res(1, 6, 1)});
      rows.push_back('{mk(199, 11, 31, 23, 59, 59, 4), 1'b1, res(1, 4, 367)});
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0), 1'b1, res(0, 0, 0)});
      rows.push_back('{mk(255, 15, 31, 31, 63, 63, 7), 1'b1, res(0, 0, 0)});
      // Month index beyond December zeroes both computed values
      rows.push_back('{mk(150, 12, 15, 12, 30, 30, 3), 1'b1, res(0, 0, 0)});
      rows.push_back('{mk(150, 13, 1, 0, 0, 0, 0), 1'b1, res(0, 0, 0)});
      rows.push_back('{mk(120, 14, 20, 5, 5, 5, 2), 1'b1, res(0, 0, 0)});
      // Leap handling: 2024, 2000, 2100 and 1900
      rows.push_back('{mk(124, 1, 29, 12, 0, 0, 4), 1'b0, '0});
      rows.push_back('{mk(100, 2, 1, 0, 0, 0, 3), 1'b0, '0});
      rows.push_back('{mk(200, 2, 1, 0, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(0, 11, 31, 0, 0, 0, 1), 1'b0, '0});
      // Year just outside the range on either side
      rows.push_back('{mk(99, 5, 10, 8, 15, 45, 6), 1'b0, '0});
      rows.push_back('{mk(200, 5, 10, 8, 15, 45, 5), 1'b0, '0});
      // Time and weekday fields one past their limit; the hour also at its top
      rows.push_back('{mk(130, 4, 12, 24, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(130, 4, 12, 31, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(130, 4, 12, 10, 60, 0, 1), 1'b0, '0});
      rows.push_back('{mk(130, 4, 12, 10, 0, 60, 1), 1'b0, '0});
      rows.push_back('{mk(130, 4, 12, 10, 0, 0, 7), 1'b0, '0});
      // Day zero and an impossible February day still compute
      rows.push_back('{mk(130, 3, 0, 10, 0, 0, 1), 1'b0, '0});
      rows.push_back('{mk(130, 1, 31, 10, 0, 0, 1), 1'b0, '0});
      // Around the July/August turn of the day-of-year count, and its maximum
      rows.push_back('{mk(116, 6, 31, 1, 2, 3, 0), 1'b0, '0});
      rows.push_back('{mk(116, 7, 1, 1, 2, 3, 1), 1'b0, '0});
      rows.push_back('{mk(100, 11, 31, 23, 59, 59, 0), 1'b0, '0});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_date(rows[i].item, rows[i].pinned, rows[i].result);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // Switch between idling and back-to-back stretches
         if (n % 50 == 0)
            burst = ($urandom_range(0, 3) == 0);
         send_date(random_date(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      burst = 1'b0;

      // Let the last accepted item reach the queue before waiting on it
      @(posedge clock);
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_dates.size() == 0) begin
         $display("date_check_weekday_yearday regression: pass");
      end else begin
         $display("date_check_weekday_yearday regression: fail");
      end
      $finish;
   end

   // Response side: stall at random before each result, except during back-to-back stretches
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = burst ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Record each accepted item's expectation, then check each accepted result
   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_dates.push_back(pinned ? pinned_result : date_result(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (pending_dates.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_payload);
               error_count++;
            end else begin
               want = pending_dates.pop_front();
               if (rsp_payload.date_valid !== want.date_valid) begin
                  $error("date_valid: expected %0d, got %0d",
                         want.date_valid, rsp_payload.date_valid);
                  error_count++;
               end
               if (rsp_payload.weekday !== want.weekday) begin
                  $error("weekday: expected %0d, got %0d", want.weekday, rsp_payload.weekday);
                  error_count++;
               end
               if (rsp_payload.day_of_year !== want.day_of_year) begin
                  $error("day_of_year: expected %0d, got %0d",
                         want.day_of_year, rsp_payload.day_of_year);
                  error_count++;
               end
            end
         end
      end
   end

   // Abandon a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("date_check_weekday_yearday regression: fail");
         $finish;
      end
   end

endmodule
